### src/sccc_pkg.sv
package sccc_pkg;

    localparam int NumSetsDef    = 64;
    localparam int NumWaysDef    = 8;
    localparam int BlockBytesDef = 64;
    localparam int AddrW         = 32;
    localparam int TsW           = 32;
    localparam int StW           = 3;

    typedef enum logic [2:0] {
        MODE_RD    = 3'd0,
        MODE_WR    = 3'd1,
        MODE_S_RD  = 3'd2,
        MODE_S_RDX = 3'd3,
        MODE_S_UPD = 3'd4
    } t_mode;

    localparam logic [StW-1:0] ST_INV   = 3'd0;
    localparam logic [StW-1:0] ST_CLEAN = 3'd1;
    localparam logic [StW-1:0] ST_MOD   = 3'd2;
    localparam logic [StW-1:0] ST_EXCL  = 3'd3;
    localparam logic [StW-1:0] ST_SC    = 3'd4;
    localparam logic [StW-1:0] ST_SM    = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT,
        S_CLR
    } t_state;

    function automatic int flog2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

### src/sccc_if.sv
interface sccc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [31:0] address;
    logic       sole_copy;
    modport source (output valid, mode, address, sole_copy, input ready);
    modport sink (input valid, mode, address, sole_copy, output ready);
endinterface

interface sccc_out_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       issue_bus_read;
    logic       issue_bus_read_excl;
    logic       issue_bus_update;
    logic       victim_writeback;
    logic       flush;
    logic       invalidated;
    logic       intervention;
    logic [1:0] mem_xact_count;
    modport source (output valid, hit, issue_bus_read, issue_bus_read_excl,
        issue_bus_update, victim_writeback, flush, invalidated, intervention,
        mem_xact_count, input ready);
    modport sink (input valid, hit, issue_bus_read, issue_bus_read_excl,
        issue_bus_update, victim_writeback, flush, invalidated, intervention,
        mem_xact_count, output ready);
endinterface

interface sccc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### src/sccc_ram.sv
module sccc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/snooping_coherent_cache_controller_unit.sv
// channel | dir | fields
// i_req   | in  | mode, address, sole_copy
// o_rsp   | out | hit, bus commands, writeback, flush, invalidated, intervention, mem count
// i_cfg   | in  | protocol_select (1 bit)
//
// each transaction goes through accept, lookup on the set read from memory, result out
// the set is one memory word (state, tag and timestamp of all ways side by side),
// read once and written back at most once
// after reset a clearing pass writes every set invalid, one set a cycle; requests wait
// for all NUM_SETS sets (64 by default); reset clears access clock and protocol_select
// a stalled result holds the block; the next request is taken the cycle after it leaves
module snooping_coherent_cache_controller_unit
    import sccc_pkg::*;
#(
    parameter int NUM_SETS    = NumSetsDef,
    parameter int NUM_WAYS    = NumWaysDef,
    parameter int BLOCK_BYTES = BlockBytesDef
) (
    input logic      i_clk,
    input logic      i_rst_n,
    sccc_in_if.sink  i_req,
    sccc_out_if.source o_rsp,
    sccc_cfg_if.sink i_cfg
);
    localparam int BbW  = flog2(BLOCK_BYTES);
    localparam int SbW  = flog2(NUM_SETS);
    localparam int SetN = 1 << SbW;
    localparam int SetA = (SbW > 0) ? SbW : 1;
    localparam int TagW = AddrW - BbW - SbW;
    localparam int WayA = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int EntW = TagW + TsW + StW;
    localparam int RowW = EntW * NUM_WAYS;

    t_state r_st, n_st;
    logic r_proto;
    logic [TsW-1:0] r_clk_cnt;
    logic [SetA-1:0] r_clr_idx;
    logic [2:0] r_mode;
    logic [TagW-1:0] r_tag;
    logic [SetA-1:0] r_set;
    logic r_sole;
    logic r_hit, r_brd, r_brdx, r_bupd, r_wb, r_fl, r_inv, r_itv;
    logic [1:0] r_mem;

    logic [SetA-1:0] w_set_in;
    logic [SetA-1:0] w_waddr;
    logic [RowW-1:0] w_row, w_wrow;
    logic w_we;

    assign w_set_in = (SbW > 0) ? SetA'(i_req.address >> BbW) : '0;
    // clearing pass owns the write port right after reset
    assign w_waddr = (r_st == S_CLR) ? r_clr_idx : r_set;

    sccc_ram #(.Width(RowW), .Depth(SetN)) u_row (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wrow),
        .i_raddr(w_set_in),
        .o_rdata(w_row)
    );

    assign i_req.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = (r_st == S_OUT);

    // lookup logic on the registered set
    logic [NUM_WAYS-1:0] w_match, w_inv;
    logic [StW-1:0] w_ws [NUM_WAYS];
    logic [TsW-1:0] w_ts [NUM_WAYS];
    logic [TagW-1:0] w_tg [NUM_WAYS];
    logic w_found, w_anyinv;
    logic [WayA-1:0] w_hway, w_iway, w_lway, w_vway, w_tway;
    logic [TsW-1:0] w_mn;
    logic [StW-1:0] w_cur, w_new;
    logic [TsW-1:0] w_nclk;
    logic o_hit, o_brd, o_brdx, o_bupd, o_wb, o_fl, o_inv, o_itv;
    logic [1:0] o_mem;
    logic w_upd;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_tg[w] = w_row[w*EntW +: TagW];
            w_ts[w] = w_row[w*EntW + TagW +: TsW];
            w_ws[w] = w_row[w*EntW + TagW + TsW +: StW];
            w_inv[w] = (w_ws[w] == ST_INV);
            w_match[w] = !w_inv[w] && (w_tg[w] == r_tag);
        end
        w_found = 1'b0;
        w_hway = '0;
        w_anyinv = 1'b0;
        w_iway = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_found = 1'b1;
                w_hway = WayA'(w);
            end
            if (w_inv[w]) begin
                w_anyinv = 1'b1;
                w_iway = WayA'(w);
            end
        end
        w_mn = w_ts[0];
        w_lway = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w_ts[w] <= w_mn) begin
                w_mn = w_ts[w];
                w_lway = WayA'(w);
            end
        end
        w_vway = w_anyinv ? w_iway : w_lway;
    end

    always_comb begin
        w_nclk = r_clk_cnt + 1'b1;
        o_hit = 1'b0; o_brd = 1'b0; o_brdx = 1'b0; o_bupd = 1'b0; o_wb = 1'b0;
        o_fl = 1'b0; o_inv = 1'b0; o_itv = 1'b0; o_mem = 2'd0;
        w_tway = w_hway;
        w_cur = w_ws[w_hway];
        w_new = w_cur;
        w_upd = 1'b0;
        w_we = 1'b0;
        w_wrow = w_row;
        if (r_mode <= 3'(MODE_S_UPD)) begin
            o_hit = w_found;
        end
        if (r_mode == 3'(MODE_RD) || r_mode == 3'(MODE_WR)) begin
            w_upd = 1'b1;
            if (!w_found) begin
                w_tway = w_vway;
                w_cur = w_ws[w_vway];
                o_mem = 2'd1;
                if (w_cur == ST_MOD || w_cur == ST_SM) begin
                    o_wb = 1'b1;
                    o_mem = 2'd2;
                end
                if (!r_proto) begin
                    if (r_mode == 3'(MODE_WR)) begin
                        o_brdx = 1'b1; w_new = ST_MOD;
                    end else begin
                        o_brd = 1'b1; w_new = ST_CLEAN;
                    end
                end else begin
                    o_brd = 1'b1;
                    if (r_mode == 3'(MODE_WR)) begin
                        if (r_sole) w_new = ST_MOD;
                        else begin
                            o_bupd = 1'b1; w_new = ST_SM;
                        end
                    end else begin
                        w_new = r_sole ? ST_EXCL : ST_SC;
                    end
                end
            end else if (r_mode == 3'(MODE_WR)) begin
                if (!r_proto) w_new = ST_MOD;
                else if (w_cur == ST_SC || w_cur == ST_SM) begin
                    o_bupd = 1'b1;
                    w_new = r_sole ? ST_MOD : ST_SM;
                end else if (w_cur == ST_EXCL) w_new = ST_MOD;
            end
            w_wrow[w_tway*EntW +: EntW] = {w_new, w_nclk, r_tag};
        end else if (w_found && r_mode <= 3'(MODE_S_UPD)) begin
            w_upd = 1'b1;
            if (!r_proto) begin
                if (r_mode == 3'(MODE_S_RD) || r_mode == 3'(MODE_S_RDX)) begin
                    if (w_cur == ST_MOD) begin
                        o_fl = 1'b1; o_inv = 1'b1; o_mem = 2'd1; w_new = ST_INV;
                    end else if (w_cur == ST_CLEAN) begin
                        o_inv = 1'b1; w_new = ST_INV;
                    end
                end
            end else if (r_mode == 3'(MODE_S_RD)) begin
                if (w_cur == ST_MOD || w_cur == ST_SM) begin
                    o_itv = (w_cur == ST_MOD);
                    w_new = ST_SM; o_fl = 1'b1; o_mem = 2'd1;
                end else if (w_cur == ST_EXCL) begin
                    o_itv = 1'b1; w_new = ST_SC;
                end
            end else if (r_mode == 3'(MODE_S_UPD)) begin
                if (w_cur == ST_SM) w_new = ST_SC;
            end
            // snoops touch only the state of the matching way
            w_wrow[w_hway*EntW + TagW + TsW +: StW] = w_new;
        end
        if (r_st == S_CLR) begin
            w_we = 1'b1;
            w_wrow = '0;
        end else begin
            w_we = (r_st == S_LOOK) && w_upd;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLR:  if (r_clr_idx == SetA'(SetN - 1)) n_st = S_IDLE;
            S_IDLE: if (i_req.valid) n_st = S_LOOK;
            S_LOOK: n_st = S_OUT;
            S_OUT:  if (o_rsp.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_proto <= 1'b0;
            r_clk_cnt <= '0;
            r_clr_idx <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLR) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cfg.valid) r_proto <= i_cfg.data;
            if (r_st == S_LOOK) begin
                if (r_mode == 3'(MODE_RD) || r_mode == 3'(MODE_WR)) r_clk_cnt <= w_nclk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req.valid) begin
            r_mode <= i_req.mode;
            r_tag  <= TagW'(i_req.address >> (BbW + SbW));
            r_set  <= w_set_in;
            r_sole <= i_req.sole_copy;
        end
        if (r_st == S_LOOK) begin
            r_hit <= o_hit; r_brd <= o_brd; r_brdx <= o_brdx; r_bupd <= o_bupd;
            r_wb <= o_wb; r_fl <= o_fl; r_inv <= o_inv; r_itv <= o_itv; r_mem <= o_mem;
        end
    end

    assign o_rsp.hit = r_hit;
    assign o_rsp.issue_bus_read = r_brd;
    assign o_rsp.issue_bus_read_excl = r_brdx;
    assign o_rsp.issue_bus_update = r_bupd;
    assign o_rsp.victim_writeback = r_wb;
    assign o_rsp.flush = r_fl;
    assign o_rsp.invalidated = r_inv;
    assign o_rsp.intervention = r_itv;
    assign o_rsp.mem_xact_count = r_mem;

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.victim_writeback |-> !o_rsp.hit) else $error("wb on hit");
    a_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.mem_xact_count != 2'd3) else $error("mem count");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_LOOK |=> r_st == S_OUT) else $error("sequence");
endmodule

### dv/snooping_coherent_cache_controller_unit_tb.sv
`timescale 1ns / 1ps
module snooping_coherent_cache_controller_unit_tb;
    import sccc_pkg::*;

    localparam int SETS  = NumSetsDef;
    localparam int WAYS  = NumWaysDef;
    localparam int OFF_B = 6;
    localparam int IDX_B = 6;

    typedef struct packed {
        logic       hit;
        logic       brd;
        logic       brdx;
        logic       bupd;
        logic       wb;
        logic       fl;
        logic       inv;
        logic       itv;
        logic [1:0] mem;
    } t_rsp;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] addr;
        logic        sole;
        logic        has_exp;
        t_rsp        exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   n_sent;
    int   n_got;
    int   n_dragon;

    sccc_in_if  req_if ();
    sccc_out_if rsp_if ();
    sccc_cfg_if cfg_if ();

    snooping_coherent_cache_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // predictor copy of the tag store
    logic [31:0] line_tag [SETS*WAYS];
    logic [2:0]  line_st  [SETS*WAYS];
    logic [31:0] line_ts  [SETS*WAYS];
    logic [31:0] acc_clk;
    logic        dragon;
    t_rsp        pending_rsp [$];
    t_rsp        forced_rsp [$];
    logic        forced_use [$];

    always #5 i_clk = ~i_clk;

    function automatic t_rsp coherence_step(logic [2:0] mode, logic [31:0] addr, logic sole);
        t_rsp r;
        int set, base, way, v, w;
        logic [31:0] tag, mn;
        logic [2:0] s;
        r = '0;
        set = (addr >> OFF_B) & (SETS - 1);
        tag = addr >> (OFF_B + IDX_B);
        base = set * WAYS;
        if (mode > MODE_S_UPD) return r;
        way = -1;
        for (w = 0; w < WAYS; w++)
            if (way < 0 && line_st[base+w] != ST_INV && line_tag[base+w] == tag) way = w;
        r.hit = (way >= 0);
        if (mode <= MODE_WR) begin
            acc_clk++;
            if (way < 0) begin
                v = -1;
                for (w = 0; w < WAYS; w++)
                    if (v < 0 && line_st[base+w] == ST_INV) v = w;
                if (v < 0) begin
                    mn = line_ts[base];
                    v = 0;
                    for (w = 0; w < WAYS; w++)
                        if (line_ts[base+w] <= mn) begin
                            v = w;
                            mn = line_ts[base+w];
                        end
                end
                v = base + v;
                r.mem = 2'd1;
                if (line_st[v] == ST_MOD || line_st[v] == ST_SM) begin
                    r.wb = 1'b1;
                    r.mem = 2'd2;
                end
                line_tag[v] = tag;
                line_ts[v] = acc_clk;
                if (!dragon) begin
                    if (mode == MODE_WR) begin r.brdx = 1'b1; s = ST_MOD; end
                    else begin r.brd = 1'b1; s = ST_CLEAN; end
                end else begin
                    r.brd = 1'b1;
                    if (mode == MODE_WR) begin
                        if (sole) s = ST_MOD;
                        else begin r.bupd = 1'b1; s = ST_SM; end
                    end else s = sole ? ST_EXCL : ST_SC;
                end
                line_st[v] = s;
            end else begin
                v = base + way;
                line_ts[v] = acc_clk;
                if (mode == MODE_WR) begin
                    if (!dragon) line_st[v] = ST_MOD;
                    else if (line_st[v] == ST_SC || line_st[v] == ST_SM) begin
                        r.bupd = 1'b1;
                        line_st[v] = sole ? ST_MOD : ST_SM;
                    end else if (line_st[v] == ST_EXCL) line_st[v] = ST_MOD;
                end
            end
        end else if (way >= 0) begin
            v = base + way;
            if (!dragon) begin
                if (mode == MODE_S_RD || mode == MODE_S_RDX) begin
                    if (line_st[v] == ST_MOD) begin
                        r.fl = 1'b1; r.inv = 1'b1; r.mem = 2'd1;
                        line_st[v] = ST_INV;
                    end else if (line_st[v] == ST_CLEAN) begin
                        r.inv = 1'b1;
                        line_st[v] = ST_INV;
                    end
                end
            end else if (mode == MODE_S_RD) begin
                if (line_st[v] == ST_MOD) begin r.itv = 1'b1; line_st[v] = ST_SM; end
                if (line_st[v] == ST_SM) begin r.fl = 1'b1; r.mem = 2'd1; end
                else if (line_st[v] == ST_EXCL) begin r.itv = 1'b1; line_st[v] = ST_SC; end
            end else if (mode == MODE_S_UPD) begin
                if (line_st[v] == ST_SM) line_st[v] = ST_SC;
            end
        end
        return r;
    endfunction

    // drive one request transaction and queue its expectation
    // valid stays high after acceptance until the next negedge decides
    task automatic send_req(logic [2:0] mode, logic [31:0] addr, logic sole,
                            logic use_fixed, t_rsp fixed);
        int gap;
        t_rsp p;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        p = coherence_step(mode, addr, sole);
        pending_rsp.push_back(p);
        forced_rsp.push_back(fixed);
        forced_use.push_back(use_fixed);
        req_if.valid     <= 1'b1;
        req_if.mode      <= mode;
        req_if.address   <= addr;
        req_if.sole_copy <= sole;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        n_sent++;
        if (dragon) n_dragon++;
        @(negedge i_clk);
    endtask

    task automatic write_protocol(logic val);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        dragon = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // response side: random stalls, compare each transaction
    initial begin
        int stall;
        t_rsp e, fx, a;
        logic uf;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            a = '{rsp_if.hit, rsp_if.issue_bus_read, rsp_if.issue_bus_read_excl,
                  rsp_if.issue_bus_update, rsp_if.victim_writeback, rsp_if.flush,
                  rsp_if.invalidated, rsp_if.intervention, rsp_if.mem_xact_count};
            n_got++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %b", $time, a);
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                fx = forced_rsp.pop_front();
                uf = forced_use.pop_front();
                if (uf && fx != e) begin
                    $display("%0t: table row disagrees, expected %b, predictor %b",
                             $time, fx, e);
                    errors++;
                end
                if (a != e) begin
                    $display("%0t: mismatch, expected %b, actual %b", $time, e, a);
                    errors++;
                end
            end
        end
    end

    // directed rows, mostly on set 0 so that the set fills and evicts
    t_row rows [$];

    function automatic t_row mk(logic [2:0] m, logic [31:0] a, logic s,
                                logic h, t_rsp e);
        t_row r;
        r.mode = m; r.addr = a; r.sole = s; r.has_exp = h; r.exp = e;
        return r;
    endfunction

    // random address drawn from a small pool of tags so hits and evictions happen
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom();
        if ($urandom_range(0, 9) != 0) begin
            a[31:12] = 20'($urandom_range(0, 11));
            if ($urandom_range(0, 1)) a[31:28] = 4'hf;
            a[11:6] = 6'($urandom_range(0, 3));
        end
        return a;
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r > 4 && $urandom_range(0, 5) != 0) r = $urandom_range(0, 1);
            else if (r > 4) r = $urandom_range(5, 7);
            send_req(3'(r), pick_addr(), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        errors = 0; n_sent = 0; n_got = 0; n_dragon = 0;
        acc_clk = '0;
        dragon = 1'b0;
        for (int i = 0; i < SETS*WAYS; i++) begin
            line_st[i] = ST_INV; line_tag[i] = '0; line_ts[i] = '0;
        end
        req_if.valid = 1'b0; req_if.mode = '0; req_if.address = '0; req_if.sole_copy = 1'b0;
        cfg_if.valid = 1'b0; cfg_if.data = 1'b0;

        // expected values here follow straight from reset state
        rows.push_back(mk(MODE_S_RD, 32'h0, 1'b0, 1'b1, '0));
        rows.push_back(mk(MODE_RD, 32'h0, 1'b0, 1'b1, 10'b0100000001));
        rows.push_back(mk(MODE_RD, 32'h0, 1'b1, 1'b1, 10'b1000000000));
        rows.push_back(mk(MODE_WR, 32'hffff_ffff, 1'b1, 1'b1, 10'b0010000001));
        rows.push_back(mk(MODE_S_RD, 32'hffff_ffc0, 1'b0, 1'b1, 10'b1000011001));
        rows.push_back(mk(MODE_S_RDX, 32'h0000_0005, 1'b0, 1'b1, 10'b1000001000));
        rows.push_back(mk(3'd5, 32'h0, 1'b1, 1'b1, '0));
        rows.push_back(mk(3'd7, 32'hffff_ffff, 1'b1, 1'b1, '0));
        // fill set 0 with nine tags to force an eviction, then a snoop update and a snoop read-exclusive
        for (int t = 1; t <= 9; t++)
            rows.push_back(mk(t[0] ? MODE_WR : MODE_RD, 32'(t) << 12, 1'b0, 1'b0, '0));
        rows.push_back(mk(MODE_S_UPD, 32'h1000, 1'b0, 1'b0, '0));
        rows.push_back(mk(MODE_S_RDX, 32'h2000, 1'b0, 1'b0, '0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // msi directed part
        foreach (rows[i]) send_req(rows[i].mode, rows[i].addr, rows[i].sole,
                                   rows[i].has_exp, rows[i].exp);
        // dragon directed: exclusive, shared, sm flush, update, intervention
        write_protocol(1'b1);
        send_req(MODE_RD, 32'h0003_0040, 1'b1, 1'b0, '0);
        send_req(MODE_S_RD, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_WR, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_S_RD, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_S_UPD, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_WR, 32'h0003_0040, 1'b1, 1'b0, '0);
        send_req(MODE_S_RD, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_S_RDX, 32'h0003_0040, 1'b0, 1'b0, '0);
        send_req(MODE_WR, 32'h0004_0040, 1'b0, 1'b0, '0);

        random_phase(250);
        write_protocol(1'b0);
        random_phase(250);
        write_protocol(1'b1);
        random_phase(250);
        write_protocol(1'b0);
        random_phase(250);

        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("ran %0d transactions (%0d under dragon), %0d results checked",
                 n_sent, n_dragon, n_got);
        $display("covered msi and dragon fills, evictions, snoops and protocol switches");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/sccc_pkg.sv
src/sccc_if.sv
src/sccc_ram.sv
src/snooping_coherent_cache_controller_unit.sv
dv/snooping_coherent_cache_controller_unit_tb.sv
